// ----- src/rsfp_pkg.sv -----
package rsfp_pkg;

  // Default depth of the operand stack
  localparam int unsigned STACK_DEPTH_DEF = 16;

  localparam int unsigned OP_W    = 5;
  localparam int unsigned VALUE_W = 64;
  localparam int unsigned WORD_W  = 32;
  localparam int unsigned LEVEL_W = 5;

  // Fields that the direct relocations keep
  localparam logic [WORD_W-1:0] KEEP_B26  = 32'hfc00_0000;
  localparam logic [WORD_W-1:0] KEEP_SI20 = 32'hfe00_001f;
  localparam logic [WORD_W-1:0] KEEP_SI12 = 32'hffc0_03ff;

  typedef enum logic [OP_W-1:0] {
    OP_PUSH       = 5'd0,
    OP_SUB        = 5'd1,
    OP_SHL        = 5'd2,
    OP_SHR        = 5'd3,
    OP_ADD        = 5'd4,
    OP_AND        = 5'd5,
    OP_IFELSE     = 5'd6,
    OP_INS_U5     = 5'd7,
    OP_INS_U12    = 5'd8,
    OP_INS_S12    = 5'd9,
    OP_INS_S16    = 5'd10,
    OP_INS_S16_S2 = 5'd11,
    OP_INS_S20    = 5'd12,
    OP_INS_S21_S2 = 5'd13,
    OP_INS_S26_S2 = 5'd14,
    OP_REL_B26    = 5'd15,
    OP_REL_HI20   = 5'd16,
    OP_REL_LO12   = 5'd17,
    OP_REL_A64H12 = 5'd18,
    OP_REL_A64L20 = 5'd19,
    OP_CLEAR      = 5'd20
  } op_e;

  // Net effect of one item on the stack
  typedef enum logic [2:0] {
    ST_HOLD,
    ST_PUSH,
    ST_REPL1,
    ST_REPL2,
    ST_POP,
    ST_CLEAR
  } stk_mode_e;

  typedef struct packed {
    logic               en;
    stk_mode_e          mode;
    logic [VALUE_W-1:0] value;
  } stk_cmd_t;

endpackage

// ----- src/rsfp_stack.sv -----
module rsfp_stack import rsfp_pkg::*; #(
  parameter int unsigned STACK_DEPTH = STACK_DEPTH_DEF,
  localparam int unsigned FillW = $clog2(STACK_DEPTH + 1)
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  stk_cmd_t                      cmd_i,
  output logic [2:0][VALUE_W-1:0]       top_o,
  output logic [FillW-1:0]              fill_o,
  output logic [FillW-1:0]              fill_next_o
);

  logic [VALUE_W-1:0] stk_q [STACK_DEPTH];
  logic [VALUE_W-1:0] stk_d [STACK_DEPTH];
  logic [FillW-1:0]   fill_q, fill_d;

  // Entry 0 is the top of stack; pushes, pops and replaces shift the entries
  for (genvar i = 0; i < STACK_DEPTH; i++) begin : g_entry
    logic [VALUE_W-1:0] dn, up1, up2;

    if (i == 0) begin : g_first
      assign dn = cmd_i.value;
    end else begin : g_rest
      assign dn = stk_q[i-1];
    end

    if (i + 1 < STACK_DEPTH) begin : g_up1
      assign up1 = stk_q[i+1];
    end else begin : g_keep1
      assign up1 = stk_q[i];
    end

    if (i + 2 < STACK_DEPTH) begin : g_up2
      assign up2 = stk_q[i+2];
    end else begin : g_keep2
      assign up2 = stk_q[i];
    end

    always_comb begin
      case (cmd_i.mode)
        ST_PUSH:  stk_d[i] = dn;
        ST_REPL1: stk_d[i] = (i == 0) ? cmd_i.value : up1;
        ST_REPL2: stk_d[i] = (i == 0) ? cmd_i.value : up2;
        ST_POP:   stk_d[i] = up1;
        default:  stk_d[i] = stk_q[i];
      endcase
    end

    always_ff @(posedge clk_i) begin
      if (cmd_i.en) begin
        stk_q[i] <= stk_d[i];
      end
    end
  end

  always_comb begin
    fill_d = fill_q;
    if (cmd_i.en) begin
      case (cmd_i.mode)
        ST_PUSH:  fill_d = fill_q + FillW'(1);
        ST_REPL1: fill_d = (fill_q >= FillW'(2)) ? fill_q - FillW'(1) : FillW'(1);
        ST_REPL2: fill_d = (fill_q >= FillW'(3)) ? fill_q - FillW'(2) : FillW'(1);
        ST_POP:   fill_d = (fill_q != '0) ? fill_q - FillW'(1) : '0;
        ST_CLEAR: fill_d = '0;
        default:  fill_d = fill_q;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      fill_q <= '0;
    end else begin
      fill_q <= fill_d;
    end
  end

  assign top_o[0]    = stk_q[0];
  assign top_o[1]    = stk_q[1];
  assign top_o[2]    = stk_q[2];
  assign fill_o      = fill_q;
  assign fill_next_o = fill_d;

  a_fill_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    fill_q <= FillW'(STACK_DEPTH))
    else $error("stack fill beyond depth");

  a_clear_empties: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_i.en && cmd_i.mode == ST_CLEAR |=> fill_q == '0)
    else $error("clear did not empty the stack");

  a_push_grows: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_i.en && cmd_i.mode == ST_PUSH |=> fill_q == $past(fill_q) + FillW'(1))
    else $error("push did not grow the stack by one");

endmodule

// ----- src/rsfp_exec.sv -----
module rsfp_exec import rsfp_pkg::*; #(
  parameter int unsigned STACK_DEPTH = STACK_DEPTH_DEF,
  localparam int unsigned FillW = $clog2(STACK_DEPTH + 1)
) (
  input  logic                    go_i,
  input  logic [OP_W-1:0]         op_i,
  input  logic [VALUE_W-1:0]      value_i,
  input  logic [WORD_W-1:0]       word_i,
  input  logic [2:0][VALUE_W-1:0] top_i,
  input  logic [FillW-1:0]        fill_i,
  output stk_cmd_t                cmd_o,
  output logic [WORD_W-1:0]       word_o,
  output logic                    fault_o
);

  logic [VALUE_W-1:0] t0, t1, t2;
  logic [VALUE_W-1:0] shl_res, shr_res;
  logic               empty, short2, short3, full;
  op_e                op;

  assign op     = op_e'(op_i);
  assign empty  = (fill_i == '0);
  assign short2 = (fill_i < FillW'(2));
  assign short3 = (fill_i < FillW'(3));
  assign full   = (fill_i == FillW'(STACK_DEPTH));

  // Pops past the bottom read as zero
  assign t0 = (fill_i >= FillW'(1)) ? top_i[0] : '0;
  assign t1 = (fill_i >= FillW'(2)) ? top_i[1] : '0;
  assign t2 = (fill_i >= FillW'(3)) ? top_i[2] : '0;

  assign shl_res = (t0[VALUE_W-1:6] == '0) ? (t1 << t0[5:0]) : '0;
  assign shr_res = (t0[VALUE_W-1:6] == '0) ? (t1 >> t0[5:0]) : '0;

  always_comb begin
    cmd_o.en    = go_i;
    cmd_o.mode  = ST_HOLD;
    cmd_o.value = '0;
    word_o      = '0;
    fault_o     = 1'b0;
    case (op)
      OP_PUSH: begin
        fault_o = full;
        if (!full) begin
          cmd_o.mode  = ST_PUSH;
          cmd_o.value = value_i;
        end
      end
      OP_SUB: begin
        cmd_o.mode = ST_REPL1; cmd_o.value = t1 - t0; fault_o = short2;
      end
      OP_SHL: begin
        cmd_o.mode = ST_REPL1; cmd_o.value = shl_res; fault_o = short2;
      end
      OP_SHR: begin
        cmd_o.mode = ST_REPL1; cmd_o.value = shr_res; fault_o = short2;
      end
      OP_ADD: begin
        cmd_o.mode = ST_REPL1; cmd_o.value = t1 + t0; fault_o = short2;
      end
      OP_AND: begin
        cmd_o.mode = ST_REPL1; cmd_o.value = t1 & t0; fault_o = short2;
      end
      OP_IFELSE: begin
        // pop c, b, a; keep b when a is nonzero
        cmd_o.mode  = ST_REPL2;
        cmd_o.value = (t2 != '0) ? t1 : t0;
        fault_o     = short3;
      end
      OP_INS_U5: begin
        cmd_o.mode = ST_POP; fault_o = empty;
        word_o = word_i | (WORD_W'(t0[4:0]) << 10);
      end
      OP_INS_U12, OP_INS_S12: begin
        cmd_o.mode = ST_POP; fault_o = empty;
        word_o = word_i | (WORD_W'(t0[11:0]) << 10);
      end
      OP_INS_S16: begin
        cmd_o.mode = ST_POP; fault_o = empty;
        word_o = word_i | (WORD_W'(t0[15:0]) << 10);
      end
      OP_INS_S16_S2: begin
        cmd_o.mode = ST_POP; fault_o = empty;
        word_o = word_i | (WORD_W'(t0[17:2]) << 10);
      end
      OP_INS_S20: begin
        cmd_o.mode = ST_POP; fault_o = empty;
        word_o = word_i | (WORD_W'(t0[19:0]) << 5);
      end
      OP_INS_S21_S2: begin
        cmd_o.mode = ST_POP; fault_o = empty;
        word_o = word_i | (WORD_W'(t0[17:2]) << 10) | WORD_W'(t0[22:18]);
      end
      OP_INS_S26_S2: begin
        cmd_o.mode = ST_POP; fault_o = empty;
        word_o = word_i | (WORD_W'(t0[17:2]) << 10) | WORD_W'(t0[27:18]);
      end
      OP_REL_B26: begin
        word_o = (word_i & KEEP_B26)
               | ((WORD_W'(value_i[27:18]) | (WORD_W'(value_i[17:2]) << 10)) & ~KEEP_B26);
      end
      OP_REL_HI20: begin
        word_o = (word_i & KEEP_SI20) | ((WORD_W'(value_i[31:12]) << 5) & ~KEEP_SI20);
      end
      OP_REL_LO12: begin
        word_o = (word_i & KEEP_SI12) | ((WORD_W'(value_i[11:0]) << 10) & ~KEEP_SI12);
      end
      OP_REL_A64H12: begin
        word_o = (word_i & KEEP_SI12) | ((WORD_W'(value_i[63:52]) << 10) & ~KEEP_SI12);
      end
      OP_REL_A64L20: begin
        word_o = (word_i & KEEP_SI20) | ((WORD_W'(value_i[51:32]) << 5) & ~KEEP_SI20);
      end
      OP_CLEAR: begin
        cmd_o.mode = ST_CLEAR;
      end
      default: begin
        cmd_o.mode = ST_HOLD;
      end
    endcase
  end

endmodule

// ----- src/relocation_stack_field_patcher.sv -----
// Path: an accepted transfer is held in the input register, then executed and its
//   result loaded into the result register once that register is free.
// Throughput: one item per cycle while the output is not stalled; the operand stack is
//   updated at the same edge that loads the result register, so the next item sees the updated stack at once.
// Reset: rst_ni (asynchronous, active low) empties the stack and drops both valids;
//   stack entries hold no reset value and are only read once pushed.
module relocation_stack_field_patcher import rsfp_pkg::*; #(
  parameter int unsigned STACK_DEPTH = STACK_DEPTH_DEF
) (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               in_valid_i,
  output logic               in_stall_o,
  input  logic [OP_W-1:0]    op_i,
  input  logic [VALUE_W-1:0] operand_value_i,
  input  logic [WORD_W-1:0]  instruction_word_i,
  output logic               out_valid_o,
  input  logic               out_stall_i,
  output logic [WORD_W-1:0]  patched_word_o,
  output logic [LEVEL_W-1:0] stack_level_o,
  output logic               stack_fault_o
);

  localparam int unsigned FillW = $clog2(STACK_DEPTH + 1);

  // Input register
  logic               in_vld_q, in_vld_d;
  logic [OP_W-1:0]    op_q;
  logic [VALUE_W-1:0] value_q;
  logic [WORD_W-1:0]  word_q;

  // Result register
  logic               out_vld_q, out_vld_d;
  logic [WORD_W-1:0]  res_word_q;
  logic [LEVEL_W-1:0] res_level_q;
  logic               res_fault_q;

  logic                    res_free, exec_go, in_take;
  stk_cmd_t                stk_cmd;
  logic [2:0][VALUE_W-1:0] stk_top;
  logic [FillW-1:0]        stk_fill, stk_fill_next;
  logic [WORD_W-1:0]       exec_word;
  logic                    exec_fault;

  // Result register can take a new result when empty or being drained now.
  assign res_free = !out_vld_q || !out_stall_i;
  // Execute the held item whenever its result has somewhere to go.
  assign exec_go  = in_vld_q && res_free;
  // Stall the input only while a held item cannot move on.
  assign in_stall_o = in_vld_q && !exec_go;
  assign in_take    = in_valid_i && !in_stall_o;

  always_comb begin
    in_vld_d = in_vld_q;
    if (exec_go || !in_vld_q) begin
      in_vld_d = in_valid_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_vld_q <= 1'b0;
    end else begin
      in_vld_q <= in_vld_d;
    end
  end

  // Payload: load on every transfer, hold otherwise.
  always_ff @(posedge clk_i) begin
    if (in_take) begin
      op_q    <= op_i;
      value_q <= operand_value_i;
      word_q  <= instruction_word_i;
    end
  end

  rsfp_exec #(
    .STACK_DEPTH(STACK_DEPTH)
  ) u_exec (
    .go_i    (exec_go),
    .op_i    (op_q),
    .value_i (value_q),
    .word_i  (word_q),
    .top_i   (stk_top),
    .fill_i  (stk_fill),
    .cmd_o   (stk_cmd),
    .word_o  (exec_word),
    .fault_o (exec_fault)
  );

  rsfp_stack #(
    .STACK_DEPTH(STACK_DEPTH)
  ) u_stack (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cmd_i       (stk_cmd),
    .top_o       (stk_top),
    .fill_o      (stk_fill),
    .fill_next_o (stk_fill_next)
  );

  // Keep a result until it is taken; drop valid once drained with nothing new.
  always_comb begin
    out_vld_d = out_vld_q;
    if (exec_go) begin
      out_vld_d = 1'b1;
    end else if (!out_stall_i) begin
      out_vld_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_vld_q <= 1'b0;
    end else begin
      out_vld_q <= out_vld_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (exec_go) begin
      res_word_q  <= exec_word;
      // Report the fill after this item, wrapped to the port width.
      res_level_q <= LEVEL_W'(stk_fill_next);
      res_fault_q <= exec_fault;
    end
  end

  assign out_valid_o    = out_vld_q;
  assign patched_word_o = res_word_q;
  assign stack_level_o  = res_level_q;
  assign stack_fault_o  = res_fault_q;

  a_exec_fills_result: assert property (@(posedge clk_i) disable iff (!rst_ni)
    exec_go |=> out_vld_q)
    else $error("executed item left no result");

  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_stall_i |=> out_valid_o && $stable(patched_word_o)
      && $stable(stack_level_o) && $stable(stack_fault_o))
    else $error("stalled result changed");

  a_stall_cause: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_stall_o |-> out_valid_o && out_stall_i)
    else $error("input stalled without a blocked result");

endmodule

// ----- tb/sv/tb_relocation_stack_field_patcher.sv -----
`timescale 1ns / 100ps

module tb_relocation_stack_field_patcher;
  import rsfp_pkg::*;

  // Op codes the block leaves unused: state holds, result reports the level only
  localparam logic [OP_W-1:0] OP_UNUSED_LO = 5'd21;
  localparam logic [OP_W-1:0] OP_UNUSED_HI = 5'd31;

  localparam int unsigned RAND_ITEMS = 615;

  // One result transfer: patched word, stack level and fault flag
  typedef struct {
    logic [WORD_W-1:0]  word;
    logic [LEVEL_W-1:0] level;
    logic               fault;
  } patch_res_t;

  // One row of the directed table; reps repeats the same transfer
  typedef struct {
    logic [OP_W-1:0]    op;
    logic [VALUE_W-1:0] value;
    logic [WORD_W-1:0]  word;
    int unsigned        reps;
    bit                 typed;
    patch_res_t         res;
  } dir_row_t;

  logic               clk_i;
  logic               rst_ni;
  logic               in_valid_i;
  logic               in_stall_o;
  logic [OP_W-1:0]    op_i;
  logic [VALUE_W-1:0] operand_value_i;
  logic [WORD_W-1:0]  instruction_word_i;
  logic               out_valid_o;
  logic               out_stall_i;
  logic [WORD_W-1:0]  patched_word_o;
  logic [LEVEL_W-1:0] stack_level_o;
  logic               stack_fault_o;

  // Expected results, oldest first
  patch_res_t  patch_q[$];
  dir_row_t    dir_rows[$];
  int unsigned err_cnt;
  int unsigned sent_cnt;

  // Idle rates in percent, changed per phase
  int unsigned send_idle_pct;
  int unsigned recv_idle_pct;

  // Shadow of the operand stack
  logic [VALUE_W-1:0] shadow_stack[STACK_DEPTH_DEF];
  int unsigned        shadow_fill;
  logic               shadow_fault;

  relocation_stack_field_patcher i_dut (
    .clk_i              (clk_i),
    .rst_ni             (rst_ni),
    .in_valid_i         (in_valid_i),
    .in_stall_o         (in_stall_o),
    .op_i               (op_i),
    .operand_value_i    (operand_value_i),
    .instruction_word_i (instruction_word_i),
    .out_valid_o        (out_valid_o),
    .out_stall_i        (out_stall_i),
    .patched_word_o     (patched_word_o),
    .stack_level_o      (stack_level_o),
    .stack_fault_o      (stack_fault_o)
  );

  always begin
    clk_i = 1'b1;
    #10;
    clk_i = 1'b0;
    #10;
  end

  // ---------------------------------------------------------------------------
  // Shadow stack helpers: an empty pop yields zero, a full push is dropped;
  // both raise the fault flag for the current item.
  // ---------------------------------------------------------------------------
  function automatic logic [VALUE_W-1:0] shadow_pop();
    if (shadow_fill == 0) begin
      shadow_fault = 1'b1;
      return '0;
    end
    shadow_fill--;
    return shadow_stack[shadow_fill];
  endfunction

  function automatic void shadow_push(input logic [VALUE_W-1:0] v);
    if (shadow_fill >= STACK_DEPTH_DEF) begin
      shadow_fault = 1'b1;
      return;
    end
    shadow_stack[shadow_fill] = v;
    shadow_fill++;
  endfunction

  // Evaluate one relocation op on the shadow stack and return its result
  function automatic patch_res_t eval_reloc_op(input logic [OP_W-1:0] op,
                                               input logic [VALUE_W-1:0] v,
                                               input logic [WORD_W-1:0] w);
    logic [VALUE_W-1:0] a, b, c;
    logic [WORD_W-1:0]  pw;
    patch_res_t         r;
    pw = '0;
    shadow_fault = 1'b0;
    case (op)
      OP_PUSH: shadow_push(v);
      OP_SUB: begin
        b = shadow_pop();
        a = shadow_pop();
        shadow_push(a - b);
      end
      OP_SHL: begin
        b = shadow_pop();
        a = shadow_pop();
        shadow_push((b >= 64) ? '0 : (a << b[5:0]));
      end
      OP_SHR: begin
        b = shadow_pop();
        a = shadow_pop();
        shadow_push((b >= 64) ? '0 : (a >> b[5:0]));
      end
      OP_ADD: begin
        b = shadow_pop();
        a = shadow_pop();
        shadow_push(a + b);
      end
      OP_AND: begin
        b = shadow_pop();
        a = shadow_pop();
        shadow_push(a & b);
      end
      OP_IFELSE: begin
        c = shadow_pop();
        b = shadow_pop();
        a = shadow_pop();
        shadow_push((a != 0) ? b : c);
      end
      OP_INS_U5: begin
        a = shadow_pop();
        pw = w | (32'(a[4:0]) << 10);
      end
      OP_INS_U12, OP_INS_S12: begin
        a = shadow_pop();
        pw = w | (32'(a[11:0]) << 10);
      end
      OP_INS_S16: begin
        a = shadow_pop();
        pw = w | (32'(a[15:0]) << 10);
      end
      OP_INS_S16_S2: begin
        a = shadow_pop();
        pw = w | (32'(a[17:2]) << 10);
      end
      OP_INS_S20: begin
        a = shadow_pop();
        pw = w | (32'(a[19:0]) << 5);
      end
      OP_INS_S21_S2: begin
        a = shadow_pop();
        pw = w | (32'(a[17:2]) << 10) | 32'(a[22:18]);
      end
      OP_INS_S26_S2: begin
        a = shadow_pop();
        pw = w | (32'(a[17:2]) << 10) | 32'(a[27:18]);
      end
      // Direct relocations: clear the field, then insert offset bits
      OP_REL_B26:
        pw = (w & KEEP_B26) | ((32'(v[27:18]) | (32'(v[17:2]) << 10)) & ~KEEP_B26);
      OP_REL_HI20:
        pw = (w & KEEP_SI20) | ((32'(v[31:12]) << 5) & ~KEEP_SI20);
      OP_REL_LO12:
        pw = (w & KEEP_SI12) | ((32'(v[11:0]) << 10) & ~KEEP_SI12);
      OP_REL_A64H12:
        pw = (w & KEEP_SI12) | ((32'(v[63:52]) << 10) & ~KEEP_SI12);
      OP_REL_A64L20:
        pw = (w & KEEP_SI20) | ((32'(v[51:32]) << 5) & ~KEEP_SI20);
      OP_CLEAR: shadow_fill = 0;
      default: ;
    endcase
    r.word  = pw;
    r.level = LEVEL_W'(shadow_fill);
    r.fault = shadow_fault;
    return r;
  endfunction

  // Operand values biased toward edges: zero, all ones, single bits, shift counts
  function automatic logic [VALUE_W-1:0] pick_value();
    case ($urandom_range(0, 5))
      0:       return '0;
      1:       return '1;
      2:       return 64'(1) << $urandom_range(0, 63);
      3:       return 64'($urandom_range(0, 70));
      default: return {$urandom, $urandom};
    endcase
  endfunction

  function automatic logic [WORD_W-1:0] pick_word();
    case ($urandom_range(0, 3))
      0:       return '0;
      1:       return '1;
      default: return $urandom;
    endcase
  endfunction

  task automatic add_row(input logic [OP_W-1:0] op, input logic [VALUE_W-1:0] v,
                         input logic [WORD_W-1:0] w, input int unsigned reps,
                         input bit typed, input logic [WORD_W-1:0] ew,
                         input logic [LEVEL_W-1:0] el, input logic ef);
    dir_row_t row;
    row.op        = op;
    row.value     = v;
    row.word      = w;
    row.reps      = reps;
    row.typed     = typed;
    row.res.word  = ew;
    row.res.level = el;
    row.res.fault = ef;
    dir_rows.push_back(row);
  endtask

  // ---------------------------------------------------------------------------
  // Sender: called at a falling edge, leaves at a falling edge. Insert random
  // gaps, hold the payload until the transfer, then queue the expectation.
  // A typed result replaces the predicted one; the shadow state advances anyway.
  // ---------------------------------------------------------------------------
  task automatic send_op(input logic [OP_W-1:0] op, input logic [VALUE_W-1:0] v,
                         input logic [WORD_W-1:0] w, input bit typed,
                         input patch_res_t typed_res);
    patch_res_t pred;
    while ($urandom_range(0, 99) < send_idle_pct) begin
      in_valid_i <= 1'b0;
      @(negedge clk_i);
    end
    in_valid_i         <= 1'b1;
    op_i               <= op;
    operand_value_i    <= v;
    instruction_word_i <= w;
    @(posedge clk_i);
    while (in_stall_o) @(posedge clk_i);
    pred = eval_reloc_op(op, v, w);
    patch_q.push_back(typed ? typed_res : pred);
    sent_cnt++;
    @(negedge clk_i);
  endtask

  task automatic send_pred(input logic [OP_W-1:0] op, input logic [VALUE_W-1:0] v,
                           input logic [WORD_W-1:0] w);
    patch_res_t none;
    none = '{default: '0};
    send_op(op, v, w, 1'b0, none);
  endtask

  // Receiver: stall at random, rate set per phase
  always @(negedge clk_i) begin
    out_stall_i <= ($urandom_range(0, 99) < recv_idle_pct);
  end

  // Checker: compare each result transfer with the oldest expectation
  always @(posedge clk_i) begin
    patch_res_t exp_res;
    if (rst_ni && out_valid_o && !out_stall_i) begin
      if (patch_q.size() == 0) begin
        $display("%0t: unexpected result word=%h level=%0d fault=%0b", $time,
                 patched_word_o, stack_level_o, stack_fault_o);
        err_cnt++;
      end else begin
        exp_res = patch_q.pop_front();
        if (patched_word_o !== exp_res.word) begin
          $display("%0t: patched_word expected %h actual %h", $time,
                   exp_res.word, patched_word_o);
          err_cnt++;
        end
        if (stack_level_o !== exp_res.level) begin
          $display("%0t: stack_level expected %0d actual %0d", $time,
                   exp_res.level, stack_level_o);
          err_cnt++;
        end
        if (stack_fault_o !== exp_res.fault) begin
          $display("%0t: stack_fault expected %0b actual %0b", $time,
                   exp_res.fault, stack_fault_o);
          err_cnt++;
        end
      end
    end
  end

  // Hard limit on the run
  initial begin
    #5_000_000;
    $display("== FAIL ==");
    $finish;
  end

  initial begin
    int unsigned        dir_cnt;
    int unsigned        kind;
    int unsigned        burst;
    logic [OP_W-1:0]    bin_op;
    logic [VALUE_W-1:0] rhs;

    // Drive every input known before reset
    rst_ni             = 1'b0;
    in_valid_i         = 1'b0;
    op_i               = '0;
    operand_value_i    = '0;
    instruction_word_i = '0;
    out_stall_i        = 1'b0;
    err_cnt            = 0;
    sent_cnt           = 0;
    shadow_fill        = 0;
    shadow_fault       = 1'b0;
    send_idle_pct      = 17;
    recv_idle_pct      = 72;

    // Directed table: op, value, word, repeats, typed?, word, level, fault
    // Empty-stack pops yield zero and fault; the push of the difference still lands
    add_row(OP_SUB, '0, '0, 1, 1, 32'h0000_0000, 5'd1, 1'b1);
    add_row(OP_CLEAR, '1, '1, 1, 1, 32'h0000_0000, 5'd0, 1'b0);
    add_row(OP_INS_U5, '0, 32'hffff_ffff, 1, 1, 32'hffff_ffff, 5'd0, 1'b1);
    // Direct relocations at the extremes of offset and word
    add_row(OP_REL_B26, '1, 32'h0000_0000, 1, 1, 32'h03ff_ffff, 5'd0, 1'b0);
    add_row(OP_REL_HI20, '0, 32'hffff_ffff, 1, 1, 32'hfe00_001f, 5'd0, 1'b0);
    add_row(OP_REL_LO12, 64'h0000_0000_0000_0fff, '0, 1, 1, 32'h003f_fc00, 5'd0, 1'b0);
    add_row(OP_REL_A64H12, 64'hfff0_0000_0000_0000, '0, 1, 1, 32'h003f_fc00, 5'd0, 1'b0);
    add_row(OP_REL_A64L20, 64'h000f_ffff_0000_0000, '0, 1, 1, 32'h01ff_ffe0, 5'd0, 1'b0);
    // Fill the stack, then push once more: the value is dropped with a fault
    add_row(OP_PUSH, '1, '0, STACK_DEPTH_DEF, 0, '0, '0, 1'b0);
    add_row(OP_PUSH, '0, '0, 1, 1, 32'h0000_0000, 5'd16, 1'b1);
    add_row(OP_UNUSED_LO, '1, '1, 1, 1, 32'h0000_0000, 5'd16, 1'b0);
    add_row(OP_UNUSED_HI, '1, '1, 1, 1, 32'h0000_0000, 5'd16, 1'b0);
    // Shift by all ones gives zero, then a shift by zero, then a select
    add_row(OP_SHL, '0, '0, 1, 0, '0, '0, 1'b0);
    add_row(OP_SHR, '0, '0, 1, 0, '0, '0, 1'b0);
    add_row(OP_IFELSE, '0, '0, 1, 0, '0, '0, 1'b0);
    add_row(OP_INS_S26_S2, '0, '0, 1, 0, '0, '0, 1'b0);
    add_row(OP_CLEAR, '0, '0, 1, 1, 32'h0000_0000, 5'd0, 1'b0);

    repeat (6) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni = 1'b1;
    @(negedge clk_i);

    foreach (dir_rows[i]) begin
      repeat (dir_rows[i].reps) begin
        send_op(dir_rows[i].op, dir_rows[i].value, dir_rows[i].word,
                dir_rows[i].typed, dir_rows[i].res);
      end
    end
    dir_cnt = sent_cnt;

    // Random part: mostly well-formed expressions that end in a field insert,
    // plus direct relocations, deep push bursts, clears and noise
    while (sent_cnt < dir_cnt + RAND_ITEMS) begin
      // Swap the idle rates after a third, drop idling after two thirds
      if (sent_cnt >= dir_cnt + 2 * RAND_ITEMS / 3) begin
        send_idle_pct = 0;
        recv_idle_pct = 0;
      end else if (sent_cnt >= dir_cnt + RAND_ITEMS / 3) begin
        send_idle_pct = 72;
        recv_idle_pct = 17;
      end
      kind = $urandom_range(0, 99);
      if (kind < 60) begin
        // Push two operands, combine, maybe select, then mostly patch a word
        bin_op = OP_W'(OP_PUSH + $urandom_range(1, 5));
        rhs = (bin_op == OP_SHL || bin_op == OP_SHR) ?
              64'($urandom_range(0, 70)) : pick_value();
        send_pred(OP_PUSH, pick_value(), pick_word());
        send_pred(OP_PUSH, rhs, pick_word());
        send_pred(bin_op, pick_value(), pick_word());
        if ($urandom_range(0, 3) == 0) begin
          send_pred(OP_PUSH, pick_value(), pick_word());
          send_pred(OP_PUSH, pick_value(), pick_word());
          send_pred(OP_IFELSE, pick_value(), pick_word());
        end
        if ($urandom_range(0, 9) < 7) begin
          send_pred(OP_W'(OP_INS_U5 + $urandom_range(0, 7)), pick_value(), pick_word());
        end
      end else if (kind < 75) begin
        send_pred(OP_W'(OP_REL_B26 + $urandom_range(0, 4)), pick_value(), pick_word());
      end else if (kind < 85) begin
        // Burst of pushes, often past full
        burst = $urandom_range(1, 20);
        repeat (burst) send_pred(OP_PUSH, pick_value(), pick_word());
      end else if (kind < 90) begin
        send_pred(OP_CLEAR, pick_value(), pick_word());
      end else if (kind < 95) begin
        send_pred(OP_W'(OP_UNUSED_LO + $urandom_range(0, OP_UNUSED_HI - OP_UNUSED_LO)),
                  pick_value(), pick_word());
      end else begin
        // Any op with any payload: pops on an empty stack, odd shift counts
        send_pred(OP_W'($urandom_range(0, 31)), {$urandom, $urandom}, $urandom);
      end
    end
    in_valid_i <= 1'b0;

    // Drain outstanding results, then let the pipeline settle
    while (patch_q.size() != 0) @(posedge clk_i);
    repeat (4) @(posedge clk_i);

    if (err_cnt == 0) begin
      $display("== PASS ==");
    end else begin
      $display("== FAIL ==");
    end
    $finish;
  end

endmodule
